// ===== hdl/mdd_pkg.sv =====
package mdd_pkg;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] REG_HIHAT_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HIHAT_MIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RATIO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HOLDOFF = 2'd3;

   // register reset values
   localparam logic [15:0] RST_HIHAT_WINDOW = 16'd1200;
   localparam logic [4:0] RST_HIHAT_MIN = 5'd7;
   localparam logic [9:0] RST_RATIO = 10'd346;
   localparam logic [15:0] RST_HOLDOFF = 16'd5000;

   // energy average: alpha = 1311 / 65536, Q24.8 with 1.0 = 256
   localparam logic [10:0] ALPHA_NEW = 11'd1311;
   localparam logic [15:0] ALPHA_KEEP = 16'd64225;
   localparam logic [31:0] ONE_Q8 = 32'd256;

   localparam logic [4:0] COUNT_MAX = 5'd31;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SCAN,
      ST_TALLY,
      ST_FINISH
   } state_type;

endpackage

// ===== hdl/music_drop_detector.sv =====
// Music drop detector: one decision per audio frame request.
// A request passes PREP, SCAN and TALLY to FINISH, which loads the response once the
// response register is free; no new request is taken before that. The scan walks the
// hi-hat time memory, one slot read per cycle through its single read port.
// Reset (synchronous, active high): registers to 1200/7/346/5000, all slots read as zero,
// write slot 0, energy average 1.0 (256), last drop time 0, no response pending.
module music_drop_detector #(
   parameter int HIHAT_SLOTS = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [31:0]                       req_now_ms,
   input  logic [31:0]                       req_total_energy,
   input  logic                              req_kick,
   input  logic                              req_hihat,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_drop,
   output logic [4:0]                        rsp_recent_hihats,
   // configuration writes
   input  logic                              csr_we,
   input  logic [mdd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mdd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int IDX_W = (HIHAT_SLOTS > 1) ? $clog2(HIHAT_SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HIHAT_SLOTS - 1);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [15:0] window_ff;
   logic [4:0]  min_count_ff;
   logic [9:0]  ratio_ff;
   logic [15:0] holdoff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= mdd_pkg::RST_HIHAT_WINDOW;
         min_count_ff <= mdd_pkg::RST_HIHAT_MIN;
         ratio_ff     <= mdd_pkg::RST_RATIO;
         holdoff_ff   <= mdd_pkg::RST_HOLDOFF;
      end else if (csr_we) begin
         unique case (csr_index)
            mdd_pkg::REG_HIHAT_WINDOW: window_ff    <= csr_wdata;
            mdd_pkg::REG_HIHAT_MIN:    min_count_ff <= csr_wdata[4:0];
            mdd_pkg::REG_RATIO:        ratio_ff     <= csr_wdata[9:0];
            mdd_pkg::REG_HOLDOFF:      holdoff_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Captured request
   // ---------------------------------------------------------------
   logic [31:0] now_ff;
   logic [31:0] energy_ff;
   logic        kick_ff;
   logic        hihat_ff;

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         now_ff    <= req_now_ms;
         energy_ff <= req_total_energy;
         kick_ff   <= req_kick;
         hihat_ff  <= req_hihat;
      end
   end

   // ---------------------------------------------------------------
   // Sequencer
   //   IDLE   : take a request, capture its fields
   //   PREP   : store the hi-hat time, start the three products
   //   SCAN   : read one slot per cycle, count the previous read
   //   TALLY  : count the last slot read
   //   FINISH : decide, load the response register, update the average
   // The slot write in PREP lands before the first read in SCAN, so the
   // current frame's hi-hat is always read back by its own scan.
   // ---------------------------------------------------------------
   mdd_pkg::state_type state_ff, state_in;

   logic             mem_we;
   logic             rsp_load;
   logic             rsp_valid_ff;
   logic [IDX_W-1:0] scan_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mdd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      mem_we    = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         mdd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = mdd_pkg::ST_PREP;
            end
         end
         mdd_pkg::ST_PREP: begin
            mem_we   = hihat_ff;
            state_in = mdd_pkg::ST_SCAN;
         end
         mdd_pkg::ST_SCAN: begin
            if (scan_idx_ff == LAST_IDX) begin
               state_in = mdd_pkg::ST_TALLY;
            end
         end
         mdd_pkg::ST_TALLY: begin
            state_in = mdd_pkg::ST_FINISH;
         end
         mdd_pkg::ST_FINISH: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = mdd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mdd_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Hi-hat time memory: one write port, one registered read port.
   // A slot never written since reset reads as zero through its live bit.
   // ---------------------------------------------------------------
   logic [31:0]            hit_mem [HIHAT_SLOTS];
   logic [31:0]            rd_data_ff;
   logic [HIHAT_SLOTS-1:0] slot_live_ff;
   logic                   rd_live_ff;
   logic                   rd_pend_ff;
   logic [IDX_W-1:0]       write_slot_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hit_mem[write_slot_ff] <= now_ff;
      end
      rd_data_ff <= hit_mem[scan_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_live_ff  <= '0;
         write_slot_ff <= '0;
         rd_pend_ff    <= 1'b0;
      end else begin
         rd_pend_ff <= (state_ff == mdd_pkg::ST_SCAN);
         if (mem_we) begin
            slot_live_ff[write_slot_ff] <= 1'b1;
            write_slot_ff <= (write_slot_ff == LAST_IDX) ? '0 : write_slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_live_ff <= slot_live_ff[scan_idx_ff];
      if (state_ff == mdd_pkg::ST_PREP) begin
         scan_idx_ff <= '0;
      end else if (state_ff == mdd_pkg::ST_SCAN && scan_idx_ff != LAST_IDX) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Recent hi-hat count: age wraps modulo 2^32, saturate at 31
   // ---------------------------------------------------------------
   logic [31:0] slot_time;
   logic [31:0] slot_age;
   logic        slot_recent;
   logic [4:0]  count_ff, count_in;

   always_comb begin
      slot_time   = rd_live_ff ? rd_data_ff : '0;
      slot_age    = now_ff - slot_time;
      slot_recent = slot_age < {16'd0, window_ff};
      count_in    = count_ff;
      if (rd_pend_ff && slot_recent && count_ff != mdd_pkg::COUNT_MAX) begin
         count_in = count_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == mdd_pkg::ST_PREP) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // ---------------------------------------------------------------
   // Energy products, registered in PREP and held while the scan runs
   // ---------------------------------------------------------------
   logic [31:0] avg_ff;
   logic [47:0] keep_prod_ff;
   logic [42:0] new_prod_ff;
   logic [42:0] ratio_prod_ff;
   logic [32:0] avg_plus_one;

   assign avg_plus_one = {1'b0, avg_ff} + {1'b0, mdd_pkg::ONE_Q8};

   always_ff @(posedge clock) begin
      if (state_ff == mdd_pkg::ST_PREP) begin
         keep_prod_ff  <= avg_ff * mdd_pkg::ALPHA_KEEP;
         new_prod_ff   <= energy_ff * mdd_pkg::ALPHA_NEW;
         ratio_prod_ff <= ratio_ff * avg_plus_one;
      end
   end

   // ---------------------------------------------------------------
   // Decision
   // ---------------------------------------------------------------
   logic [48:0] avg_sum;
   logic [31:0] avg_in;
   logic        ratio_ok;
   logic [31:0] since_drop;
   logic        holdoff_clear;
   logic        drop_hit;
   logic [31:0] last_drop_ff;

   always_comb begin
      avg_sum       = {1'b0, keep_prod_ff} + {6'd0, new_prod_ff};
      avg_in        = avg_sum[47:16];
      ratio_ok      = {4'd0, energy_ff, 8'd0} > {1'b0, ratio_prod_ff};
      since_drop    = now_ff - last_drop_ff;
      holdoff_clear = since_drop >= {16'd0, holdoff_ff};
      drop_hit      = holdoff_clear && (count_ff > min_count_ff) && kick_ff && ratio_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff       <= mdd_pkg::ONE_Q8;
         last_drop_ff <= '0;
      end else if (rsp_load) begin
         // update the average even while the holdoff blocks a drop
         avg_ff <= avg_in;
         if (drop_hit) begin
            last_drop_ff <= now_ff;
         end
      end
   end

   // ---------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------
   logic       rsp_drop_ff;
   logic [4:0] rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_drop_ff  <= drop_hit;
         rsp_count_ff <= count_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drop          = rsp_drop_ff;
   assign rsp_recent_hihats = rsp_count_ff;

endmodule

// ===== hdl/mdd_checker.sv =====
module mdd_checker #(
   parameter int HIHAT_SLOTS = 20
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [31:0]                       req_now_ms,
   input logic [31:0]                       req_total_energy,
   input logic                              req_kick,
   input logic                              req_hihat,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_drop,
   input logic [4:0]                        rsp_recent_hihats,
   input logic                              csr_we,
   input logic [mdd_pkg::CSR_IDX_W-1:0]     csr_index,
   input logic [mdd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam logic [4:0] COUNT_CAP = (HIHAT_SLOTS > 31) ? 5'd31 : 5'(HIHAT_SLOTS);

   // a pending response stays until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before acceptance");

   // a drop needs at least one recent hi-hat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drop |-> rsp_recent_hihats != 5'd0)
      else $error("drop reported with no recent hi-hat");

   // the count never exceeds the slot count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_recent_hihats <= COUNT_CAP)
      else $error("recent hi-hat count beyond slot count");

   // reset leaves the block ready and with nothing pending
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind music_drop_detector mdd_checker #(.HIHAT_SLOTS(HIHAT_SLOTS)) u_mdd_checker (.*);
